// ===== rtl/core/cse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the channel status record extractor.
// ----------------------------------------------------------------------------
package cse_pkg;

    // slot limit per packet
    localparam int MAX_SATELLITES = 20;
    localparam int SLOT_CNT_W     = 7;
    localparam logic [SLOT_CNT_W-1:0] MAX_SATS = SLOT_CNT_W'(MAX_SATELLITES);

    // packet layout
    localparam logic [15:0] POS_MAX       = 16'hFFFF;
    localparam logic [15:0] OFF_START     = 16'd0;
    localparam logic [15:0] OFF_CMD       = 16'd3;
    localparam logic [15:0] OFF_LEN_LO    = 16'd4;
    localparam logic [15:0] OFF_LEN_HI    = 16'd5;
    localparam logic [15:0] OFF_STATUS    = 16'd13;
    localparam logic [15:0] OFF_VISIBLE   = 16'd15;
    localparam logic [15:0] OFF_USED      = 16'd17;
    localparam logic [15:0] OFF_PDOP      = 16'd18;
    localparam logic [15:0] RECORD_BASE   = 16'd20;
    localparam logic [15:0] PAYLOAD_SHIFT = 16'd3;
    localparam logic [7:0]  CHANNEL_CMD   = 8'h86;

    // byte offsets inside a 14-byte satellite record
    localparam logic [3:0] REC_PRN   = 4'd0;
    localparam logic [3:0] REC_TRK   = 4'd1;
    localparam logic [3:0] REC_ELE   = 4'd5;
    localparam logic [3:0] REC_AZ_LO = 4'd6;
    localparam logic [3:0] REC_AZ_HI = 4'd7;
    localparam logic [3:0] REC_CA    = 4'd8;
    localparam logic [3:0] REC_P2    = 4'd10;
    localparam logic [3:0] REC_LAST  = 4'd13;

    // status decoding
    localparam logic [7:0] STATUS_MASK = 8'h05;
    localparam logic [7:0] STATUS_DIFF = 8'h05;
    localparam logic [7:0] STATUS_GPS  = 8'h01;

    // result kinds
    localparam logic [1:0] KIND_SAT      = 2'd0;
    localparam logic [1:0] KIND_FIX      = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    // fix codes
    localparam logic [1:0] FIX_NONE = 2'd0;
    localparam logic [1:0] FIX_GPS  = 2'd1;
    localparam logic [1:0] FIX_DIFF = 2'd2;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  slot;
        logic [7:0]  prn;
        logic [7:0]  elevation;
        logic [15:0] azimuth;
        logic [7:0]  signal_quarter_db;
        logic [1:0]  fix_status;
        logic [7:0]  visible_cnt;
        logic [7:0]  used_cnt;
        logic [7:0]  pdop_tenths;
        logic        last;
    } result_t;

    // up to two results per byte; b only together with a
    typedef struct packed {
        logic    a_valid;
        logic    b_valid;
        result_t a;
        result_t b;
    } push_t;

endpackage

// ===== rtl/core/cse_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_parser
// Byte position tracking, header capture and satellite record decode.
// ----------------------------------------------------------------------------
module cse_parser
    import cse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] data_byte,
    input  logic       start_of_packet,
    input  logic       end_of_packet,
    output push_t      push
);

    // control state
    logic [15:0]           pos_reg, pos_next;
    logic                  chan_reg, chan_next;
    logic [15:0]           len_reg, len_next;
    logic [7:0]            status_reg, status_next;
    logic [7:0]            vis_reg, vis_next;
    logic [7:0]            used_reg, used_next;
    logic [7:0]            pdop_reg, pdop_next;
    logic [3:0]            roff_reg, roff_next;
    logic [SLOT_CNT_W-1:0] slots_reg, slots_next;
    logic                  ovf_reg, ovf_next;

    // current record fields
    logic [7:0]  prn_reg, prn_next;
    logic [7:0]  trk_reg, trk_next;
    logic [7:0]  ele_reg, ele_next;
    logic [15:0] az_reg, az_next;
    logic [7:0]  ca_reg, ca_next;

    logic [15:0] pos;
    logic        first;
    logic [15:0] rec_start;
    logic        counted;
    logic        sat_emit;
    logic        sum_emit;
    logic [7:0]  status_bits;
    result_t     sat_res;
    result_t     sum_res;

    always_comb begin
        pos       = start_of_packet ? OFF_START : pos_reg;
        first     = (pos == OFF_START);

        pos_next    = pos_reg;
        chan_next   = chan_reg;
        len_next    = len_reg;
        status_next = status_reg;
        vis_next    = vis_reg;
        used_next   = used_reg;
        pdop_next   = pdop_reg;
        roff_next   = roff_reg;
        slots_next  = slots_reg;
        ovf_next    = ovf_reg;
        prn_next    = prn_reg;
        trk_next    = trk_reg;
        ele_next    = ele_reg;
        az_next     = az_reg;
        ca_next     = ca_reg;
        sat_emit    = 1'b0;
        sum_emit    = 1'b0;

        if (in_accept && first) begin
            chan_next   = 1'b0;
            len_next    = '0;
            status_next = '0;
            vis_next    = '0;
            used_next   = '0;
            pdop_next   = '0;
            roff_next   = '0;
            slots_next  = '0;
            ovf_next    = 1'b0;
        end

        rec_start = pos - {12'd0, roff_next} - PAYLOAD_SHIFT;
        counted   = (rec_start < len_next);

        if (in_accept && pos != POS_MAX) begin
            case (pos)
                OFF_CMD:     chan_next   = (data_byte == CHANNEL_CMD);
                OFF_LEN_LO:  len_next    = {len_next[15:8], data_byte};
                OFF_LEN_HI:  len_next    = {data_byte, len_next[7:0]};
                OFF_STATUS:  status_next = data_byte;
                OFF_VISIBLE: vis_next    = data_byte;
                OFF_USED:    used_next   = data_byte;
                OFF_PDOP:    pdop_next   = data_byte;
                default:     ;
            endcase

            if (pos >= RECORD_BASE && chan_next) begin
                case (roff_next)
                    REC_PRN: begin
                        prn_next = data_byte;
                        if (counted && slots_next >= MAX_SATS) begin
                            ovf_next = 1'b1;
                        end
                    end
                    REC_TRK:   trk_next = data_byte;
                    REC_ELE:   ele_next = data_byte;
                    REC_AZ_LO: az_next  = {az_reg[15:8], data_byte};
                    REC_AZ_HI: az_next  = {data_byte, az_reg[7:0]};
                    REC_CA:    ca_next  = data_byte;
                    REC_P2: begin
                        sat_emit = !ovf_next && counted && (trk_reg != 8'd0);
                    end
                    default: ;
                endcase
                roff_next = (roff_next == REC_LAST) ? 4'd0 : roff_next + 4'd1;
            end
        end

        if (in_accept) begin
            pos_next = (pos != POS_MAX) ? pos + 16'd1 : POS_MAX;
            if (end_of_packet) begin
                pos_next = OFF_START;
                sum_emit = chan_next;
            end
        end

        if (sat_emit) begin
            slots_next = slots_reg + SLOT_CNT_W'(1);
        end

        sat_res                   = '0;
        sat_res.kind              = KIND_SAT;
        sat_res.slot              = slots_reg[5:0];
        sat_res.prn               = prn_reg;
        sat_res.elevation         = ele_reg;
        sat_res.azimuth           = az_reg;
        sat_res.signal_quarter_db = (data_byte != 8'd0) ? data_byte : ca_reg;

        status_bits = status_next & STATUS_MASK;
        sum_res      = '0;
        sum_res.last = 1'b1;
        if (ovf_next) begin
            sum_res.kind = KIND_OVERFLOW;
        end else begin
            sum_res.kind         = KIND_FIX;
            sum_res.fix_status   = (status_bits == STATUS_DIFF) ? FIX_DIFF :
                                   (status_bits == STATUS_GPS)  ? FIX_GPS  : FIX_NONE;
            sum_res.visible_cnt  = vis_next;
            sum_res.used_cnt     = used_next;
            sum_res.pdop_tenths  = pdop_next;
        end

        push.a_valid = sat_emit || sum_emit;
        push.b_valid = sat_emit && sum_emit;
        push.a       = sat_emit ? sat_res : sum_res;
        push.b       = sum_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            chan_reg   <= 1'b0;
            len_reg    <= '0;
            status_reg <= '0;
            vis_reg    <= '0;
            used_reg   <= '0;
            pdop_reg   <= '0;
            roff_reg   <= '0;
            slots_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            chan_reg   <= chan_next;
            len_reg    <= len_next;
            status_reg <= status_next;
            vis_reg    <= vis_next;
            used_reg   <= used_next;
            pdop_reg   <= pdop_next;
            roff_reg   <= roff_next;
            slots_reg  <= slots_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        prn_reg <= prn_next;
        trk_reg <= trk_next;
        ele_reg <= ele_next;
        az_reg  <= az_next;
        ca_reg  <= ca_next;
    end

    // record offset wraps within a record
    a_roff_range: assert property (@(posedge aclk) disable iff (!aresetn)
        roff_reg <= REC_LAST)
        else $error("record offset out of range");

    // no satellite result once the packet has overflowed
    a_no_sat_after_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovf_reg && !start_of_packet && pos_reg != OFF_START) |-> !sat_emit)
        else $error("satellite result after overflow");

    // slot count only moves on an emitted record or a packet start
    a_slots_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !first && !sat_emit) |=> $stable(slots_reg))
        else $error("slot count changed without a result");

endmodule

// ===== rtl/core/cse_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_result_fifo
// Four-entry result queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module cse_result_fifo
    import cse_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_item
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg, wr_next;
    logic [FIFO_AW-1:0]   rd_reg, rd_next;
    logic [FIFO_CW-1:0]   cnt_reg, cnt_next;
    logic                 pop;
    logic [FIFO_AW-1:0]   wr_b;

    assign m_valid = (cnt_reg != '0);
    assign m_item  = mem[rd_reg];
    assign room    = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop     = m_valid && m_ready;
    assign wr_b    = wr_reg + FIFO_AW'(1);

    always_comb begin
        wr_next  = wr_reg + FIFO_AW'(push.a_valid) + FIFO_AW'(push.b_valid);
        rd_next  = rd_reg + FIFO_AW'(pop);
        cnt_next = cnt_reg + FIFO_CW'(push.a_valid) + FIFO_CW'(push.b_valid)
                   - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.a_valid) begin
            mem[wr_reg] <= push.a;
        end
        if (push.b_valid) begin
            mem[wr_b] <= push.b;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.a_valid |-> room)
        else $error("result pushed without room");

    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.b_valid |-> push.a_valid)
        else $error("second result without first");

endmodule

// ===== rtl/core/channel_status_record_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_status_record_extractor
// Parses channel status packets byte by byte, emits one item per tracked record
// inside the length and slot limit, and a fix or overflow summary at packet end.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_valid/s_ready    data_byte, start_of_packet, end_of_packet
//  m_       out  m_valid/m_ready    kind, slot, prn, elevation, azimuth,
//                                   signal_quarter_db, fix_status,
//                                   visible_cnt, used_cnt, pdop_tenths, last
//
//  One byte per cycle while s_ready is high. Each accepted byte is decoded
//  in the cycle it is taken and its results (none, one or two) land in a
//  four-entry result queue; if it was empty, the first is on m_ the following cycle.
//  s_ready is high while the queue has room for two results, so bytes keep
//  flowing while earlier results wait on m_ready.
//  aresetn (synchronous) clears position, header, record offset, slot and
//  overflow state and empties the queue; the record fields are not reset.
//
module channel_status_record_extractor
    import cse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_packet,
    input  logic        s_end_of_packet,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [5:0]  m_slot,
    output logic [7:0]  m_prn,
    output logic [7:0]  m_elevation,
    output logic [15:0] m_azimuth,
    output logic [7:0]  m_signal_quarter_db,
    output logic [1:0]  m_fix_status,
    output logic [7:0]  m_visible_cnt,
    output logic [7:0]  m_used_cnt,
    output logic [7:0]  m_pdop_tenths,
    output logic        m_last
);

    logic    in_accept;
    logic    room;
    push_t   push;
    result_t m_item;

    // a byte may produce a satellite result and the summary together
    assign s_ready   = room;
    assign in_accept = s_valid && s_ready;

    cse_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .data_byte       (s_data_byte),
        .start_of_packet (s_start_of_packet),
        .end_of_packet   (s_end_of_packet),
        .push            (push)
    );

    cse_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // unpack the queue head onto the result ports
    assign m_kind              = m_item.kind;
    assign m_slot              = m_item.slot;
    assign m_prn               = m_item.prn;
    assign m_elevation         = m_item.elevation;
    assign m_azimuth           = m_item.azimuth;
    assign m_signal_quarter_db = m_item.signal_quarter_db;
    assign m_fix_status        = m_item.fix_status;
    assign m_visible_cnt       = m_item.visible_cnt;
    assign m_used_cnt          = m_item.used_cnt;
    assign m_pdop_tenths       = m_item.pdop_tenths;
    assign m_last              = m_item.last;

endmodule

// ===== tb/channel_status_record_extractor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_status_record_extractor_test
// Streams framed packets into the extractor one byte per item and checks every
// result item against a cycle-free model of the parser. A directed part covers
// the header extremes, each fix code, short and cut-off packets, missing start
// marks and the slot limit. A random part uses mostly well-formed packets,
// with truncated packets, foreign commands and noise mixed in.
// ----------------------------------------------------------------------------
module channel_status_record_extractor_test
    import cse_pkg::*;
();

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 4;
    localparam int RECORD_BYTES     = 14;
    localparam int RANDOM_BYTES     = 40;       // random bytes per idling phase
    localparam int HOLD_OFF_CYCLES  = 400;      // long receiver stall
    localparam int DRAIN_CYCLES     = 16;       // quiet time after the last result
    localparam int MAX_REPORTED     = 10;
    localparam int TIMEOUT_NS       = 2_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       sop;
        logic       eop;
    } packet_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_start_of_packet = 1'b0;
    logic        s_end_of_packet = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [5:0]  m_slot;
    logic [7:0]  m_prn;
    logic [7:0]  m_elevation;
    logic [15:0] m_azimuth;
    logic [7:0]  m_signal_quarter_db;
    logic [1:0]  m_fix_status;
    logic [7:0]  m_visible_cnt;
    logic [7:0]  m_used_cnt;
    logic [7:0]  m_pdop_tenths;
    logic        m_last;

    channel_status_record_extractor dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_start_of_packet   (s_start_of_packet),
        .s_end_of_packet     (s_end_of_packet),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_slot              (m_slot),
        .m_prn               (m_prn),
        .m_elevation         (m_elevation),
        .m_azimuth           (m_azimuth),
        .m_signal_quarter_db (m_signal_quarter_db),
        .m_fix_status        (m_fix_status),
        .m_visible_cnt       (m_visible_cnt),
        .m_used_cnt          (m_used_cnt),
        .m_pdop_tenths       (m_pdop_tenths),
        .m_last              (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Parser model. Its state mirrors the block's after reset (all zero) and
    // advances once per accepted byte.
    // ------------------------------------------------------------------------
    logic [15:0] next_pos = '0;        // offset the next byte will take
    logic        in_status_pkt = 1'b0;
    logic [15:0] pkt_length = '0;
    logic [7:0]  status_byte = '0;
    logic [7:0]  visible_sats = '0;
    logic [7:0]  used_sats = '0;
    logic [7:0]  pdop_byte = '0;
    logic [3:0]  rec_index = '0;       // byte index inside the current record
    logic [7:0]  rec_prn = '0;
    logic [7:0]  rec_track = '0;
    logic [7:0]  rec_elev = '0;
    logic [15:0] rec_az = '0;
    logic [7:0]  rec_cn0_ca = '0;
    logic [6:0]  sats_emitted = '0;
    logic        slot_overflow = 1'b0;

    result_t      predicted_results[$];  // satellite and summary items still due
    packet_byte_t byte_feed[$];          // bytes waiting for the driver
    logic [7:0]   pkt[$];                // packet under construction

    int sender_idle_pct = 10;
    int receiver_idle_pct = 49;
    int mismatch_count = 0;

    // long receiver stall, requested from the stimulus thread
    int stall_requests = 0;
    int stall_granted = 0;
    int stall_left = 0;

    task automatic start_new_packet();
        in_status_pkt = 1'b0;
        pkt_length    = '0;
        status_byte   = '0;
        visible_sats  = '0;
        used_sats     = '0;
        pdop_byte     = '0;
        rec_index     = '0;
        rec_prn       = '0;
        rec_track     = '0;
        rec_elev      = '0;
        rec_az        = '0;
        rec_cn0_ca    = '0;
        sats_emitted  = '0;
        slot_overflow = 1'b0;
    endtask

    task automatic decode_packet_byte(input logic [7:0] b, input logic sop, input logic eop);
        int unsigned pos;
        int unsigned rec_start;
        logic        counted;
        result_t     r;
        pos = sop ? 0 : next_pos;
        if (pos == 0)
            start_new_packet();

        // bytes at the saturated position are not decoded; an end mark still closes the packet
        if (pos < POS_MAX) begin
            case (pos)
                OFF_CMD:     in_status_pkt = (b == CHANNEL_CMD);
                OFF_LEN_LO:  pkt_length[7:0] = b;
                OFF_LEN_HI:  pkt_length[15:8] = b;
                OFF_STATUS:  status_byte = b;
                OFF_VISIBLE: visible_sats = b;
                OFF_USED:    used_sats = b;
                OFF_PDOP:    pdop_byte = b;
                default: ;
            endcase

            if (pos >= RECORD_BASE && in_status_pkt) begin
                // record start measured from the command byte
                rec_start = pos - rec_index - PAYLOAD_SHIFT;
                counted   = rec_start < pkt_length;
                case (rec_index)
                    REC_PRN: begin
                        rec_prn    = b;
                        rec_track  = '0;
                        rec_elev   = '0;
                        rec_az     = '0;
                        rec_cn0_ca = '0;
                        // slot limit is checked only when a counted record starts
                        if (counted && sats_emitted >= MAX_SATS)
                            slot_overflow = 1'b1;
                    end
                    REC_TRK:   rec_track = b;
                    REC_ELE:   rec_elev = b;
                    REC_AZ_LO: rec_az[7:0] = b;
                    REC_AZ_HI: rec_az[15:8] = b;
                    REC_CA:    rec_cn0_ca = b;
                    REC_P2: begin
                        if (!slot_overflow && counted && rec_track != 0) begin
                            r = '0;
                            r.kind      = KIND_SAT;
                            r.slot      = sats_emitted[5:0];
                            r.prn       = rec_prn;
                            r.elevation = rec_elev;
                            r.azimuth   = rec_az;
                            // P2 SNR, falling back to C/A when P2 is absent
                            r.signal_quarter_db = (b != 0) ? b : rec_cn0_ca;
                            predicted_results.push_back(r);
                            sats_emitted = sats_emitted + 7'd1;
                        end
                    end
                    default: ;
                endcase
                rec_index = (rec_index == REC_LAST) ? 4'd0 : rec_index + 4'd1;
            end
        end

        next_pos = (pos < POS_MAX) ? 16'(pos + 1) : POS_MAX;

        if (eop) begin
            // foreign packets end silently
            if (in_status_pkt) begin
                r = '0;
                r.last = 1'b1;
                if (slot_overflow) begin
                    r.kind = KIND_OVERFLOW;
                end else begin
                    r.kind = KIND_FIX;
                    case (status_byte & STATUS_MASK)
                        STATUS_DIFF: r.fix_status = FIX_DIFF;
                        STATUS_GPS:  r.fix_status = FIX_GPS;
                        default:     r.fix_status = FIX_NONE;
                    endcase
                    r.visible_cnt = visible_sats;
                    r.used_cnt    = used_sats;
                    r.pdop_tenths = pdop_byte;
                end
                predicted_results.push_back(r);
            end
            next_pos = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------------
    function automatic int rec_at(input int k, input logic [3:0] off);
        return RECORD_BASE + RECORD_BYTES * k + off;
    endfunction

    // Header with the given fields plus nrec random records. Most records are
    // tracked; a quarter lack a P2 SNR.
    task automatic build_status_packet(input logic [7:0] cmd, input logic [15:0] len,
                                       input logic [7:0] status, input int nrec);
        pkt.delete();
        for (int i = 0; i < RECORD_BASE; i++)
            pkt.push_back(8'($urandom));
        pkt[OFF_CMD]    = cmd;
        pkt[OFF_LEN_LO] = len[7:0];
        pkt[OFF_LEN_HI] = len[15:8];
        pkt[OFF_STATUS] = status;
        for (int k = 0; k < nrec; k++) begin
            for (int j = 0; j < RECORD_BYTES; j++)
                pkt.push_back(8'($urandom));
            if ($urandom_range(99) < 20)
                pkt[rec_at(k, REC_TRK)] = '0;
            if ($urandom_range(99) < 25)
                pkt[rec_at(k, REC_P2)] = '0;
        end
    endtask

    task automatic set_record(input int k, input logic [7:0] prn, input logic [7:0] trk,
                              input logic [7:0] ele, input logic [15:0] az,
                              input logic [7:0] ca, input logic [7:0] p2);
        pkt[rec_at(k, REC_PRN)]   = prn;
        pkt[rec_at(k, REC_TRK)]   = trk;
        pkt[rec_at(k, REC_ELE)]   = ele;
        pkt[rec_at(k, REC_AZ_LO)] = az[7:0];
        pkt[rec_at(k, REC_AZ_HI)] = az[15:8];
        pkt[rec_at(k, REC_CA)]    = ca;
        pkt[rec_at(k, REC_P2)]    = p2;
    endtask

    task automatic track_records(input int first, input int count);
        for (int k = first; k < first + count; k++)
            pkt[rec_at(k, REC_TRK)] = 8'($urandom_range(255, 1));
    endtask

    // hand the first cut bytes of pkt to the driver
    task automatic queue_packet(input bit mark_start, input bit mark_end, input int cut);
        packet_byte_t item;
        for (int i = 0; i < cut; i++) begin
            item.data = pkt[i];
            item.sop  = mark_start && (i == 0);
            item.eop  = mark_end && (i == cut - 1);
            byte_feed.push_back(item);
        end
    endtask

    // Mostly well-formed status packets with random content; the rest are
    // foreign commands, truncations, packets left open and raw noise.
    task automatic queue_random_traffic(input int budget);
        int          queued;
        int          nrec;
        int          pick;
        int          cut;
        logic [15:0] len;
        bit          open_packet;
        bit          mark_start;
        packet_byte_t item;
        queued      = 0;
        open_packet = 1'b0;
        while (queued < budget) begin
            pick = $urandom_range(99);
            if (pick < 85)
                nrec = $urandom_range(4);
            else
                nrec = $urandom_range(8, 5);

            // nominal length counts every record; sometimes off by a little or a lot
            len  = 16'(RECORD_BASE - PAYLOAD_SHIFT + RECORD_BYTES * nrec);
            pick = $urandom_range(99);
            if (pick >= 90)
                len = 16'($urandom);
            else if (pick >= 75)
                len = 16'(len + $urandom_range(28) - 14);

            pick = $urandom_range(99);
            build_status_packet((pick < 88) ? CHANNEL_CMD : 8'($urandom), len,
                                8'($urandom), nrec);
            pkt[OFF_VISIBLE] = 8'($urandom);
            pkt[OFF_USED]    = 8'($urandom);
            pkt[OFF_PDOP]    = 8'($urandom);
            // after an open packet the start mark is what realigns the parser
            mark_start = open_packet || ($urandom_range(99) < 80);

            pick = $urandom_range(99);
            if (pick < 70) begin
                cut = pkt.size();
                queue_packet(mark_start, 1'b1, cut);
                open_packet = 1'b0;
            end else if (pick < 85) begin
                cut = $urandom_range(pkt.size(), 1);
                queue_packet(mark_start, 1'b1, cut);
                open_packet = 1'b0;
            end else if (pick < 93) begin
                cut = $urandom_range(pkt.size(), 1);
                queue_packet(mark_start, 1'b0, cut);
                open_packet = 1'b1;
            end else begin
                cut = $urandom_range(24, 1);
                for (int i = 0; i < cut; i++) begin
                    item.data = 8'($urandom);
                    item.sop  = ($urandom_range(99) < 10);
                    item.eop  = (i == cut - 1) || ($urandom_range(99) < 10);
                    byte_feed.push_back(item);
                end
                open_packet = 1'b0;
            end
            queued += cut;
        end
    endtask

    // sender pause: nothing offered until every due result has arrived;
    // sampled on the falling edge, once the rising-edge updates have settled
    task automatic wait_for_drain();
        while (byte_feed.size() != 0 || s_valid || predicted_results.size() != 0)
            @(negedge aclk);
    endtask

    function automatic string describe_result(input result_t r);
        return {$sformatf("kind=%0d slot=%0d prn=%02h ele=%02h az=%04h snr=%02h ",
                          r.kind, r.slot, r.prn, r.elevation, r.azimuth,
                          r.signal_quarter_db),
                $sformatf("fix=%0d vis=%0d used=%0d pdop=%0d last=%0b",
                          r.fix_status, r.visible_cnt, r.used_cnt,
                          r.pdop_tenths, r.last)};
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one byte per handshake. A new byte is loaded only when the
    // current one is taken or none is offered, so valid and payload hold
    // steady while the block stalls.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_bytes
        packet_byte_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                decode_packet_byte(s_data_byte, s_start_of_packet, s_end_of_packet);
            if (!s_valid || s_ready) begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_item = byte_feed.pop_front();
                    s_data_byte       <= next_item.data;
                    s_start_of_packet <= next_item.sop;
                    s_end_of_packet   <= next_item.eop;
                    s_valid           <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the driver keeps offering bytes
    always @(posedge aclk) begin
        if (stall_requests != stall_granted) begin
            stall_granted <= stall_requests;
            stall_left    <= HOLD_OFF_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        result_t seen;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen.kind              = m_kind;
                seen.slot              = m_slot;
                seen.prn               = m_prn;
                seen.elevation         = m_elevation;
                seen.azimuth           = m_azimuth;
                seen.signal_quarter_db = m_signal_quarter_db;
                seen.fix_status        = m_fix_status;
                seen.visible_cnt       = m_visible_cnt;
                seen.used_cnt          = m_used_cnt;
                seen.pdop_tenths       = m_pdop_tenths;
                seen.last              = m_last;
                if (predicted_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("%0t: unexpected result %s", $realtime,
                                 describe_result(seen));
                end else begin
                    want = predicted_results.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe_result(want),
                                     describe_result(seen));
                    end
                end
            end
            m_ready <= (stall_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Right after reset, no start mark: position is already zero. Header
        // extremes; one record at the top of every field with P2 missing, one
        // at the bottom, one untracked.
        build_status_packet(CHANNEL_CMD, 16'(RECORD_BASE - PAYLOAD_SHIFT + 3 * RECORD_BYTES),
                            8'h05, 3);
        pkt[OFF_VISIBLE] = 8'hFF;
        pkt[OFF_USED]    = 8'h00;
        pkt[OFF_PDOP]    = 8'hFF;
        set_record(0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'h00);
        set_record(1, 8'h00, 8'h01, 8'h00, 16'h0000, 8'h00, 8'h01);
        set_record(2, 8'h21, 8'h00, 8'h10, 16'h1234, 8'h40, 8'h50);
        queue_packet(1'b0, 1'b1, pkt.size());

        // After an end mark the next byte is offset 0 even without a start mark.
        // Length covers only the first record; the second starts exactly at it.
        build_status_packet(CHANNEL_CMD, 16'(RECORD_BASE - PAYLOAD_SHIFT + RECORD_BYTES),
                            8'h01, 2);
        pkt[OFF_VISIBLE] = 8'h00;
        pkt[OFF_USED]    = 8'hFF;
        pkt[OFF_PDOP]    = 8'h00;
        track_records(0, 2);
        queue_packet(1'b0, 1'b1, pkt.size());

        // length one past the second record's start: it still counts; no fix
        build_status_packet(CHANNEL_CMD, 16'(RECORD_BASE - PAYLOAD_SHIFT + RECORD_BYTES + 1),
                            8'hFE, 2);
        track_records(0, 2);
        queue_packet(1'b1, 1'b1, pkt.size());

        // zero length: no record counts; status without the fix bit
        build_status_packet(CHANNEL_CMD, 16'h0000, 8'hFA, 2);
        track_records(0, 2);
        queue_packet(1'b1, 1'b1, pkt.size());

        // foreign command: silent even at the end mark
        build_status_packet(8'h85, 16'hFFFF, 8'h05, 1);
        track_records(0, 1);
        queue_packet(1'b1, 1'b1, pkt.size());

        // short packets: ends after the status byte, after the low length byte,
        // before the command byte, and a single byte carrying both marks
        build_status_packet(CHANNEL_CMD, 16'h0100, 8'h05, 0);
        queue_packet(1'b1, 1'b1, OFF_STATUS + 1);
        queue_packet(1'b1, 1'b1, OFF_LEN_LO + 1);
        queue_packet(1'b1, 1'b1, OFF_CMD);
        queue_packet(1'b1, 1'b1, 1);

        // second record cut off one byte before its P2 SNR
        build_status_packet(CHANNEL_CMD, 16'h00FF, 8'h01, 2);
        track_records(0, 2);
        queue_packet(1'b1, 1'b1, rec_at(1, REC_P2));

        // packet abandoned mid-record, then restarted by a start mark
        build_status_packet(CHANNEL_CMD, 16'h00FF, 8'h05, 2);
        track_records(0, 2);
        queue_packet(1'b1, 1'b0, rec_at(0, REC_AZ_LO));
        build_status_packet(CHANNEL_CMD, 16'h00FF, 8'h04, 2);
        track_records(0, 2);
        queue_packet(1'b1, 1'b1, pkt.size());

        // Long receiver hold-off while a slot-limit packet goes in: the result
        // queue fills and the block has to stall its input. Twenty tracked
        // records, then a counted but untracked one that still flags overflow.
        @(posedge aclk);
        stall_requests <= stall_requests + 1;
        build_status_packet(CHANNEL_CMD, 16'hFFFF, 8'h01, 21);
        track_records(0, 20);
        pkt[rec_at(20, REC_TRK)] = 8'h00;
        queue_packet(1'b1, 1'b1, pkt.size());
        wait_for_drain();

        // exactly the slot limit: the next record's first byte never arrives
        build_status_packet(CHANNEL_CMD, 16'hFFFF, 8'h05, 21);
        track_records(0, 21);
        queue_packet(1'b1, 1'b1, rec_at(20, REC_PRN));
        wait_for_drain();

        queue_random_traffic(RANDOM_BYTES);
        wait_for_drain();

        // swap the idling of the two sides
        sender_idle_pct   <= 49;
        receiver_idle_pct <= 10;
        queue_random_traffic(RANDOM_BYTES);
        wait_for_drain();

        // full rate on both sides
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
        queue_random_traffic(RANDOM_BYTES);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("== FAIL ==");
        $finish;
    end

endmodule
